### hw/rtl/alr_pkg.sv
// Shared constants, types and helpers for the anti-aliased line rasterizer.
// No dependencies; imported by every module of the block.
package alr_pkg;

    // Default geometry of the block
    localparam int COORD_INT_BITS_DEF  = 12;
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int SLOPE_FRAC_BITS_DEF = 16;
    localparam int COVERAGE_BITS_DEF   = 8;

    // Depth of the command queue between setup and pixel generation
    localparam int QUEUE_DEPTH_DEF = 2;

    // Item kinds on the input stream (tuser) and in the command queue
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Fill/empty flags of the command queue
    typedef struct packed {
        logic full;
        logic empty;
    } alr_qstat_t;

    // Round a bit count up to whole bytes
    function automatic int alr_byte_pad(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

    // Width of one queue entry:
    // kind, transposed, two endpoints (column, pixel, two coverages), slope, minor accumulator
    function automatic int alr_desc_w(input int ci, input int sf, input int cb);
        return 2 + 2 * ((ci + 1) + (ci + 2) + 2 * cb) + (sf + 2) + (ci + sf + 2);
    endfunction

endpackage

### hw/rtl/alr_queue.sv
// Short command queue between the setup front end and the pixel back end.
// Depends on alr_pkg for the status struct.
module alr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = alr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [W-1:0]        wdata,
    input  logic                pop,
    output logic [W-1:0]        rdata,
    output alr_pkg::alr_qstat_t stat
);
    import alr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Status and head entry
    always_comb
    begin
        stat.full  = (count_reg == CW'(DEPTH));
        stat.empty = (count_reg == '0);
        rdata      = entry_reg[rd_ptr_reg];
    end

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + PW'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + PW'(1));
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + CW'(1));
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/alr_front.sv
// Front end: accepts stream items, runs line setup (ordering, serial gradient divide,
// endpoint minor coordinates and coverages) and queues start and step commands.
// Depends on alr_pkg.
module alr_front #(
    parameter int COORD_INT_BITS  = alr_pkg::COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = alr_pkg::COORD_FRAC_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = alr_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int COVERAGE_BITS   = alr_pkg::COVERAGE_BITS_DEF,
    parameter int QW              = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [4*(COORD_INT_BITS+COORD_FRAC_BITS)-1:0] s_tdata,
    // func
    input  logic                s_tuser,
    output logic                q_push,
    output logic [QW-1:0]       q_data,
    input  alr_pkg::alr_qstat_t q_stat
);
    import alr_pkg::*;

    localparam int CI = COORD_INT_BITS;
    localparam int FB = COORD_FRAC_BITS;
    localparam int SF = SLOPE_FRAC_BITS;
    localparam int CB = COVERAGE_BITS;
    localparam int CW = CI + FB;
    localparam int SW = SF + 2;
    localparam int YW = CI + SF + 2;
    localparam int PW = CI + 2;
    localparam int XW = CI + 1;
    localparam int GW = FB + 1;
    localparam int NW = SF + 1 + GW;
    localparam int CNT_W = $clog2(SF + 1);
    localparam int EP_FB = SF + FB;
    localparam int SHL = (EP_FB >= CB) ? 0 : CB - EP_FB;
    localparam int SHR = (EP_FB >= CB) ? EP_FB - CB : 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_COV,
        ST_PUSH
    } state_t;

    // Endpoint coverage: truncate to CB fraction bits, saturate at all ones
    function automatic logic [CB-1:0] ep_cov(input logic [NW-1:0] num);
        logic [NW+SHL-1:0] v;
        v = (NW + SHL)'(num) << SHL;
        v = v >> SHR;
        return (|v[NW+SHL-1:CB]) ? {CB{1'b1}} : v[CB-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic              tr_reg, tr_next;
    logic [CW-1:0]     x0_reg, x0_next, y0_reg, y0_next;
    logic [CW-1:0]     x1_reg, x1_next, y1_reg, y1_next;
    logic [CW-1:0]     dx_reg, dx_next;
    logic              neg_reg, neg_next;
    logic [CW:0]       rem_reg, rem_next;
    logic [SF:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [SW-1:0] slope_reg, slope_next;
    logic signed [YW-1:0] yend_reg [2];
    logic signed [YW-1:0] yend_next [2];
    logic [GW-1:0]     gap_reg [2];
    logic [GW-1:0]     gap_next [2];
    logic [XW-1:0]     col_reg [2];
    logic [XW-1:0]     col_next [2];
    logic [PW-1:0]     pix_reg [2];
    logic [PW-1:0]     pix_next [2];
    logic [CB-1:0]     cova_reg [2];
    logic [CB-1:0]     cova_next [2];
    logic [CB-1:0]     covb_reg [2];
    logic [CB-1:0]     covb_next [2];
    logic signed [YW-1:0] accum_reg, accum_next;

    // New item: raw endpoints and their ordering
    logic [CW-1:0] ax, ay, bx, by, adx, ady, ux, uy, vx, vy;
    logic          steep, accept;

    // Divider step
    logic          div_ge;
    logic [CW:0]   div_sub, div_sel;
    logic [SF:0]   div_quo;

    // Endpoint arithmetic
    logic [CW-1:0]        ep_x [2];
    logic [CW-1:0]        ep_y [2];
    logic [CW:0]          rnd_sum [2];
    logic [FB-1:0]        rnd_frac [2];
    logic signed [GW-1:0] ofs [2];
    logic signed [SW+GW-1:0] prod [2];
    logic signed [YW-1:0] yterm [2];
    logic [SF-1:0]        fy [2];
    logic [SF:0]          omf [2];

    assign s_tready = (state_reg == ST_IDLE) && !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Ordering of a start item: transpose steep lines, then sort by major coordinate
    always_comb
    begin
        ax    = s_tdata[CW-1:0];
        ay    = s_tdata[2*CW-1:CW];
        bx    = s_tdata[3*CW-1:2*CW];
        by    = s_tdata[4*CW-1:3*CW];
        adx   = (ax > bx) ? CW'(ax - bx) : CW'(bx - ax);
        ady   = (ay > by) ? CW'(ay - by) : CW'(by - ay);
        steep = ady > adx;
        ux    = steep ? ay : ax;
        uy    = steep ? ax : ay;
        vx    = steep ? by : bx;
        vy    = steep ? bx : by;
    end

    // One restoring divide step per cycle
    always_comb
    begin
        div_ge  = rem_reg >= {1'b0, dx_reg};
        div_sub = (CW + 1)'(rem_reg - {1'b0, dx_reg});
        div_sel = div_ge ? div_sub : rem_reg;
        div_quo = {quo_reg[SF-1:0], div_ge};
    end

    // Endpoint columns, offsets and minor coordinates; coverage inputs
    always_comb
    begin
        ep_x[0] = x0_reg;
        ep_y[0] = y0_reg;
        ep_x[1] = x1_reg;
        ep_y[1] = y1_reg;
        for (int e = 0; e < 2; e++)
        begin
            rnd_sum[e]  = (CW + 1)'(ep_x[e]) + ((CW + 1)'(1) << (FB - 1));
            rnd_frac[e] = rnd_sum[e][FB-1:0];
            ofs[e]      = $signed((GW'(1) << (FB - 1)) - GW'(rnd_frac[e]));
            prod[e]     = slope_reg * ofs[e];
            yterm[e]    = $signed(YW'(ep_y[e]) << (SF - FB));
            fy[e]       = yend_reg[e][SF-1:0];
            omf[e]      = ((SF + 1)'(1) << SF) - (SF + 1)'(fy[e]);
        end
    end

    // Setup sequencer
    always_comb
    begin
        state_next = state_reg;
        tr_next    = tr_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        dx_next    = dx_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        slope_next = slope_reg;
        accum_next = accum_reg;
        for (int e = 0; e < 2; e++)
        begin
            yend_next[e] = yend_reg[e];
            gap_next[e]  = gap_reg[e];
            col_next[e]  = col_reg[e];
            pix_next[e]  = pix_reg[e];
            cova_next[e] = cova_reg[e];
            covb_next[e] = covb_reg[e];
        end
        q_push = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_STEP)
                    begin
                        q_push = 1'b1;
                    end
                    else
                    begin
                        tr_next = steep;
                        if (ux > vx)
                        begin
                            x0_next = vx;
                            y0_next = vy;
                            x1_next = ux;
                            y1_next = uy;
                        end
                        else
                        begin
                            x0_next = ux;
                            y0_next = uy;
                            x1_next = vx;
                            y1_next = vy;
                        end
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                dx_next  = CW'(x1_reg - x0_reg);
                neg_next = y1_reg < y0_reg;
                rem_next = (y1_reg < y0_reg) ? (CW + 1)'(y0_reg - y1_reg)
                                             : (CW + 1)'(y1_reg - y0_reg);
                quo_next = '0;
                cnt_next = '0;
                if (x1_reg == x0_reg)
                begin
                    slope_next = $signed(SW'(1) << SF);
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = {div_sel[CW-1:0], 1'b0};
                quo_next = div_quo;
                cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                if (cnt_reg == CNT_W'(SF))
                begin
                    slope_next = neg_reg ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo));
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                for (int e = 0; e < 2; e++)
                begin
                    yend_next[e] = yterm[e] + YW'(prod[e] >>> FB);
                    col_next[e]  = rnd_sum[e][CW:FB];
                end
                gap_next[0] = (GW'(1) << FB) - GW'(rnd_frac[0]);
                gap_next[1] = GW'(rnd_frac[1]);
                state_next  = ST_COV;
            end
            ST_COV:
            begin
                for (int e = 0; e < 2; e++)
                begin
                    pix_next[e]  = yend_reg[e][YW-1:SF];
                    cova_next[e] = ep_cov(NW'(omf[e]) * NW'(gap_reg[e]));
                    covb_next[e] = ep_cov(NW'(fy[e]) * NW'(gap_reg[e]));
                end
                accum_next = yend_reg[0] + YW'(slope_reg);
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Queue entry: a line descriptor after setup, else a bare step command
    assign q_data = {((state_reg == ST_PUSH) ? FUNC_START : FUNC_STEP), tr_reg,
                     col_reg[0], pix_reg[0], cova_reg[0], covb_reg[0],
                     col_reg[1], pix_reg[1], cova_reg[1], covb_reg[1],
                     slope_reg, accum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tr_reg    <= 1'b0;
            x0_reg    <= '0;
            y0_reg    <= '0;
            x1_reg    <= '0;
            y1_reg    <= '0;
            dx_reg    <= '0;
            neg_reg   <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            slope_reg <= '0;
            accum_reg <= '0;
            for (int e = 0; e < 2; e++)
            begin
                yend_reg[e] <= '0;
                gap_reg[e]  <= '0;
                col_reg[e]  <= '0;
                pix_reg[e]  <= '0;
                cova_reg[e] <= '0;
                covb_reg[e] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            tr_reg    <= tr_next;
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            dx_reg    <= dx_next;
            neg_reg   <= neg_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
            slope_reg <= slope_next;
            accum_reg <= accum_next;
            for (int e = 0; e < 2; e++)
            begin
                yend_reg[e] <= yend_next[e];
                gap_reg[e]  <= gap_next[e];
                col_reg[e]  <= col_next[e];
                pix_reg[e]  <= pix_next[e];
                cova_reg[e] <= cova_next[e];
                covb_reg[e] <= covb_next[e];
            end
        end
    end

endmodule

### hw/rtl/alr_back.sv
// Back end: takes line descriptors and step commands from the queue, walks the
// endpoint and interior columns and drives the registered output stream.
// Depends on alr_pkg.
module alr_back #(
    parameter int COORD_INT_BITS  = alr_pkg::COORD_INT_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = alr_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int COVERAGE_BITS   = alr_pkg::COVERAGE_BITS_DEF,
    parameter int QW              = 8,
    parameter int ODW             = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [QW-1:0]       q_data,
    input  alr_pkg::alr_qstat_t q_stat,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    // plot_x, plot_y, first_cov, second_cov from the lowest bit up
    output logic [ODW-1:0]      m_tdata,
    // second_along_x
    output logic                m_tuser,
    output logic                m_tlast
);
    import alr_pkg::*;

    localparam int CI  = COORD_INT_BITS;
    localparam int SF  = SLOPE_FRAC_BITS;
    localparam int CB  = COVERAGE_BITS;
    localparam int SW  = SF + 2;
    localparam int YW  = CI + SF + 2;
    localparam int PW  = CI + 2;
    localparam int XW  = CI + 1;
    localparam int NW  = SF + 1;
    localparam int SHL = (SF >= CB) ? 0 : CB - SF;
    localparam int SHR = (SF >= CB) ? SF - CB : 0;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_INTERIOR
    } phase_t;

    // Interior coverage: truncate to CB fraction bits, saturate at all ones
    function automatic logic [CB-1:0] in_cov(input logic [NW-1:0] num);
        logic [NW+SHL-1:0] v;
        v = (NW + SHL)'(num) << SHL;
        v = v >> SHR;
        return (|v[NW+SHL-1:CB]) ? {CB{1'b1}} : v[CB-1:0];
    endfunction

    // Head entry fields
    logic          h_kind, h_tr;
    logic [XW-1:0] h_col0, h_col1;
    logic [PW-1:0] h_pix0, h_pix1;
    logic [CB-1:0] h_ca0, h_cb0, h_ca1, h_cb1;
    logic signed [SW-1:0] h_slope;
    logic signed [YW-1:0] h_accum;

    // Line state
    logic          active_reg, active_next;
    phase_t        phase_reg, phase_next;
    logic          tr_reg, tr_next;
    logic [XW-1:0] col0_reg, col0_next, col1_reg, col1_next;
    logic [PW-1:0] pix0_reg, pix0_next, pix1_reg, pix1_next;
    logic [CB-1:0] ca0_reg, ca0_next, cb0_reg, cb0_next;
    logic [CB-1:0] ca1_reg, ca1_next, cb1_reg, cb1_next;
    logic signed [SW-1:0] slope_reg, slope_next;
    logic signed [YW-1:0] accum_reg, accum_next;
    logic [XW-1:0] cur_reg, cur_next, fin_reg, fin_next;

    // Output register
    logic          ovalid_reg, ovalid_next;
    logic [PW-1:0] px_reg, px_next, py_reg, py_next;
    logic [CB-1:0] oca_reg, oca_next, ocb_reg, ocb_next;
    logic          along_reg, along_next;
    logic          last_reg, last_next;

    // Pair under construction
    logic          out_free, emit, last;
    logic [XW-1:0] major;
    logic [PW-1:0] minor;
    logic [CB-1:0] ca, cb;
    logic [SF-1:0] fy;
    logic [SF:0]   omf;

    always_comb
    begin
        {h_kind, h_tr, h_col0, h_pix0, h_ca0, h_cb0,
         h_col1, h_pix1, h_ca1, h_cb1, h_slope, h_accum} = q_data;
    end

    // Start entries load at once; step entries need room in the output register
    assign out_free = !ovalid_reg || m_tready;
    assign q_pop    = !q_stat.empty && (h_kind == FUNC_START || out_free);

    always_comb
    begin
        fy  = accum_reg[SF-1:0];
        omf = ((SF + 1)'(1) << SF) - (SF + 1)'(fy);
    end

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        tr_next     = tr_reg;
        col0_next   = col0_reg;
        col1_next   = col1_reg;
        pix0_next   = pix0_reg;
        pix1_next   = pix1_reg;
        ca0_next    = ca0_reg;
        cb0_next    = cb0_reg;
        ca1_next    = ca1_reg;
        cb1_next    = cb1_reg;
        slope_next  = slope_reg;
        accum_next  = accum_reg;
        cur_next    = cur_reg;
        fin_next    = fin_reg;
        emit        = 1'b0;
        last        = 1'b0;
        major       = col0_reg;
        minor       = pix0_reg;
        ca          = ca0_reg;
        cb          = cb0_reg;

        if (q_pop)
        begin
            if (h_kind == FUNC_START)
            begin
                // New line replaces any line in progress
                active_next = 1'b1;
                phase_next  = PH_FIRST;
                tr_next     = h_tr;
                col0_next   = h_col0;
                col1_next   = h_col1;
                pix0_next   = h_pix0;
                pix1_next   = h_pix1;
                ca0_next    = h_ca0;
                cb0_next    = h_cb0;
                ca1_next    = h_ca1;
                cb1_next    = h_cb1;
                slope_next  = h_slope;
                accum_next  = h_accum;
                cur_next    = XW'(h_col0 + XW'(1));
                fin_next    = h_col1;
            end
            else if (active_reg)
            begin
                emit = 1'b1;
                case (phase_reg)
                    PH_FIRST:
                    begin
                        phase_next = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        major = col1_reg;
                        minor = pix1_reg;
                        ca    = ca1_reg;
                        cb    = cb1_reg;
                        last  = cur_reg >= fin_reg;
                        if (last)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_INTERIOR;
                        end
                    end
                    PH_INTERIOR:
                    begin
                        major      = cur_reg;
                        minor      = accum_reg[YW-1:SF];
                        ca         = in_cov(omf);
                        cb         = in_cov(NW'(fy));
                        last       = XW'(cur_reg + XW'(1)) >= fin_reg;
                        cur_next   = XW'(cur_reg + XW'(1));
                        accum_next = accum_reg + YW'(slope_reg);
                        if (last)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        emit        = 1'b0;
                        active_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // Output register: load a new pair or drain on transfer
    always_comb
    begin
        ovalid_next = ovalid_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        oca_next    = oca_reg;
        ocb_next    = ocb_reg;
        along_next  = along_reg;
        last_next   = last_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            px_next     = tr_reg ? minor : PW'(major);
            py_next     = tr_reg ? PW'(major) : minor;
            oca_next    = ca;
            ocb_next    = cb;
            along_next  = tr_reg;
            last_next   = last;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_FIRST;
            tr_reg     <= 1'b0;
            col0_reg   <= '0;
            col1_reg   <= '0;
            pix0_reg   <= '0;
            pix1_reg   <= '0;
            ca0_reg    <= '0;
            cb0_reg    <= '0;
            ca1_reg    <= '0;
            cb1_reg    <= '0;
            slope_reg  <= '0;
            accum_reg  <= '0;
            cur_reg    <= '0;
            fin_reg    <= '0;
            ovalid_reg <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            oca_reg    <= '0;
            ocb_reg    <= '0;
            along_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            tr_reg     <= tr_next;
            col0_reg   <= col0_next;
            col1_reg   <= col1_next;
            pix0_reg   <= pix0_next;
            pix1_reg   <= pix1_next;
            ca0_reg    <= ca0_next;
            cb0_reg    <= cb0_next;
            ca1_reg    <= ca1_next;
            cb1_reg    <= cb1_next;
            slope_reg  <= slope_next;
            accum_reg  <= accum_next;
            cur_reg    <= cur_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            oca_reg    <= oca_next;
            ocb_reg    <= ocb_next;
            along_reg  <= along_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ODW'({ocb_reg, oca_reg, py_reg, px_reg});
    assign m_tuser  = along_reg;
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/antialiased_line_rasterizer.sv
// Anti-aliased line rasterizer (Wu): top level joining setup front end, command
// queue and pixel back end. Depends on alr_pkg, alr_front, alr_queue, alr_back.
//
// Usage:
//   Input stream s_*: tuser = 0 starts a line with the endpoints in tdata
//   (unsigned fixed point), tuser = 1 asks for the next pixel pair of the line.
//   Output stream m_*: one transfer per pixel pair: first endpoint, second
//   endpoint, then interior columns; tlast marks the final pair, tuser is set
//   when the second pixel sits at x+1 (steep line), else at y+1.
//   A start transfer produces nothing; a step with no line in progress is dropped.
// Timing:
//   A start item holds s_tready low while the front end orders the endpoints, runs
//   the bit-serial gradient divider (one quotient bit per cycle; skipped when both
//   endpoints share the major coordinate) and computes both endpoint pairs, and
//   longer while the queue is full.
//   Step items are taken one per cycle while the queue has room; each pair passes
//   through the queue and then the output register before it is valid on m_*. The
//   queue lets the front end take items while the back end waits on m_tready; when
//   both are full, s_tready drops.
// Reset (rst_n, asynchronous, active low) empties the queue, drops any line in
// progress and clears m_tvalid.
module antialiased_line_rasterizer #(
    parameter int COORD_INT_BITS  = alr_pkg::COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = alr_pkg::COORD_FRAC_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = alr_pkg::SLOPE_FRAC_BITS_DEF,
    parameter int COVERAGE_BITS   = alr_pkg::COVERAGE_BITS_DEF,
    parameter int QUEUE_DEPTH     = alr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [alr_pkg::alr_byte_pad(4 * (COORD_INT_BITS + COORD_FRAC_BITS))-1:0] s_tdata,
    // func
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // plot_x, plot_y, first_cov, second_cov from the lowest bit up
    output logic [alr_pkg::alr_byte_pad(2 * (COORD_INT_BITS + 2) + 2 * COVERAGE_BITS)-1:0]
                 m_tdata,
    // second_along_x
    output logic m_tuser,
    // last_of_line
    output logic m_tlast
);
    import alr_pkg::*;

    localparam int CW  = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int QW  = alr_desc_w(COORD_INT_BITS, SLOPE_FRAC_BITS, COVERAGE_BITS);
    localparam int ODW = alr_byte_pad(2 * (COORD_INT_BITS + 2) + 2 * COVERAGE_BITS);

    logic          q_push, q_pop;
    logic [QW-1:0] q_wdata, q_rdata;
    alr_qstat_t    q_stat;

    // Setup and command issue
    alr_front #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .COVERAGE_BITS   (COVERAGE_BITS),
        .QW              (QW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata[4*CW-1:0]),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_stat   (q_stat)
    );

    // Command queue
    alr_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Pixel pair generation and output register
    alr_back #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .COVERAGE_BITS   (COVERAGE_BITS),
        .QW              (QW),
        .ODW             (ODW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_rdata),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/antialiased_line_rasterizer_test.sv
// Self-checking testbench for antialiased_line_rasterizer: a queue-fed stream driver,
// a clocked monitor with a bit-exact Wu line predictor, and randomized stall phases.
// Depends on alr_pkg and the antialiased_line_rasterizer RTL.
module antialiased_line_rasterizer_test;

    localparam int CI     = alr_pkg::COORD_INT_BITS_DEF;
    localparam int CF     = alr_pkg::COORD_FRAC_BITS_DEF;
    localparam int SF     = alr_pkg::SLOPE_FRAC_BITS_DEF;
    localparam int CB     = alr_pkg::COVERAGE_BITS_DEF;
    localparam int IN_W   = alr_pkg::alr_byte_pad(4 * (CI + CF));
    localparam int OUT_W  = alr_pkg::alr_byte_pad(2 * (CI + 2) + 2 * CB);
    localparam int PW     = CI + 2;
    localparam longint ONE   = longint'(1) << SF;
    localparam longint HALF  = longint'(1) << (CF - 1);
    localparam longint FMASK = (longint'(1) << CF) - 1;
    localparam int LIMIT     = 1500000;
    localparam int TAIL      = SF + 10;
    localparam int LONG_HOLD = 300;

    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_INTERIOR} emit_phase_t;

    typedef struct packed {
        logic        func;
        logic [15:0] ey, ex, sy, sx;
    } line_item_t;

    typedef struct packed {
        logic [PW-1:0] px, py;
        logic          along;
        logic [CB-1:0] c1, c2;
        logic          last;
    } pixel_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    antialiased_line_rasterizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and expectations
    line_item_t  stim_items[$];
    pixel_pair_t pending_pairs[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    logic in_xfer = 1'b0;
    logic drv_busy = 1'b0;
    line_item_t drv_item = '0;

    // Predictor state
    logic        ln_active = 1'b0;
    logic        ln_transposed = 1'b0;
    emit_phase_t ln_phase = PH_FIRST;
    longint      ln_ep[4] = '{0, 0, 0, 0};
    longint      ln_slope = 0;
    longint      ln_accum = 0;
    longint      ln_cur = 0;
    longint      ln_fin = 0;

    // Truncate to coverage bits and saturate 1.0 to all ones
    function automatic logic [CB-1:0] sat_cov(input longint num, input int fb);
        longint v;
        v = num >>> (fb - CB);
        return (v > (longint'(1) << CB) - 1) ? {CB{1'b1}} : v[CB-1:0];
    endfunction

    // Pixel column of an endpoint, with its minor coordinate (16 fraction bits) and gap
    function automatic longint end_column(input int e, output longint yend,
                                          output longint gap);
        longint xe, ye, xr, fr, diff;
        xe = ln_ep[2 * e];
        ye = ln_ep[2 * e + 1];
        xr = (xe + HALF) >>> CF;
        fr = (xe + HALF) & FMASK;
        diff = xr * (longint'(1) << CF) - xe;
        gap = (e == 0) ? (FMASK + 1) - fr : fr;
        yend = ye * (longint'(1) << (SF - CF)) + ((ln_slope * diff) >>> CF);
        return xr;
    endfunction

    function automatic pixel_pair_t make_pair(input longint major, input longint minor,
                                              input logic [CB-1:0] c1,
                                              input logic [CB-1:0] c2, input logic last);
        pixel_pair_t pp;
        longint px, py;
        px = ln_transposed ? minor : major;
        py = ln_transposed ? major : minor;
        pp.px = px[PW-1:0];
        pp.py = py[PW-1:0];
        pp.along = ln_transposed;
        pp.c1 = c1;
        pp.c2 = c2;
        pp.last = last;
        return pp;
    endfunction

    // Advance the line state by one accepted transfer; queue the pair it yields
    task automatic advance_line(input logic func, input logic [IN_W-1:0] data);
        longint ax, ay, bx, by, tmp, adx, ady, dxv, dyv, mag, q;
        longint yend, gap, col, pix, fy, y1, p1, p2;
        int e;
        logic last;
        if (func == alr_pkg::FUNC_START)
        begin
            ax = data[15:0];
            ay = data[31:16];
            bx = data[47:32];
            by = data[63:48];
            adx = (ax > bx) ? ax - bx : bx - ax;
            ady = (ay > by) ? ay - by : by - ay;
            ln_transposed = ady > adx;
            if (ln_transposed)
            begin
                tmp = ax; ax = ay; ay = tmp;
                tmp = bx; bx = by; by = tmp;
            end
            if (ax > bx)
            begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            ln_ep = '{ax, ay, bx, by};
            dxv = bx - ax;
            dyv = by - ay;
            if (dxv == 0)
                ln_slope = ONE;
            else
            begin
                mag = (dyv < 0) ? -dyv : dyv;
                q = (mag << SF) / dxv;
                ln_slope = (dyv < 0) ? -q : q;
            end
            p1 = end_column(0, y1, gap);
            p2 = end_column(1, yend, gap);
            ln_accum = y1 + ln_slope;
            ln_cur = p1 + 1;
            ln_fin = p2;
            ln_phase = PH_FIRST;
            ln_active = 1'b1;
        end
        else if (ln_active && ln_phase != PH_INTERIOR)
        begin
            // endpoint pairs: first, then second
            e = (ln_phase == PH_FIRST) ? 0 : 1;
            last = 1'b0;
            col = end_column(e, yend, gap);
            pix = yend >>> SF;
            fy = yend - pix * ONE;
            if (e == 1)
            begin
                last = ln_cur >= ln_fin;
                if (last)
                    ln_active = 1'b0;
                else
                    ln_phase = PH_INTERIOR;
            end
            else
                ln_phase = PH_SECOND;
            pending_pairs.push_back(make_pair(col, pix, sat_cov((ONE - fy) * gap, SF + CF),
                                              sat_cov(fy * gap, SF + CF), last));
        end
        else if (ln_active)
        begin
            // interior column
            pix = ln_accum >>> SF;
            fy = ln_accum - pix * ONE;
            last = (ln_cur + 1) >= ln_fin;
            pending_pairs.push_back(make_pair(ln_cur, pix, sat_cov(ONE - fy, SF),
                                              sat_cov(fy, SF), last));
            ln_cur += 1;
            ln_accum += ln_slope;
            if (last)
                ln_active = 1'b0;
        end
    endtask

    // Driver: one item held on the input until its transfer
    always @(negedge clk)
    begin
        if (in_xfer)
            drv_busy = 1'b0;
        if (!drv_busy && stim_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            drv_item = stim_items.pop_front();
            drv_busy = 1'b1;
        end
        s_tvalid <= drv_busy;
        s_tuser  <= drv_item.func;
        s_tdata  <= {drv_item.ey, drv_item.ex, drv_item.sy, drv_item.sx};
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_req != hold_done)
        begin
            hold_done <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        pixel_pair_t exp_pp, got_pp;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                in_xfer = s_tvalid && s_tready;
                if (in_xfer)
                    advance_line(s_tuser, s_tdata);
                if (m_tvalid && m_tready)
                begin
                    got_pp.px = m_tdata[PW-1:0];
                    got_pp.py = m_tdata[2*PW-1:PW];
                    got_pp.c1 = m_tdata[2*PW+CB-1:2*PW];
                    got_pp.c2 = m_tdata[2*PW+2*CB-1:2*PW+CB];
                    got_pp.along = m_tuser;
                    got_pp.last = m_tlast;
                    if (pending_pairs.size() == 0)
                    begin
                        mismatches++;
                        $display({"%0t: unexpected pair, expected none, got x=%0d y=%0d ",
                                  "along=%0b c=%0d/%0d last=%0b"},
                                 $time, $signed(got_pp.px), $signed(got_pp.py), got_pp.along,
                                 got_pp.c1, got_pp.c2, got_pp.last);
                    end
                    else
                    begin
                        exp_pp = pending_pairs.pop_front();
                        if (got_pp !== exp_pp)
                        begin
                            mismatches++;
                            $display({"%0t: pair mismatch, expected x=%0d y=%0d along=%0b ",
                                      "c=%0d/%0d last=%0b, got x=%0d y=%0d along=%0b ",
                                      "c=%0d/%0d last=%0b"},
                                     $time, $signed(exp_pp.px), $signed(exp_pp.py),
                                     exp_pp.along, exp_pp.c1, exp_pp.c2, exp_pp.last,
                                     $signed(got_pp.px), $signed(got_pp.py), got_pp.along,
                                     got_pp.c1, got_pp.c2, got_pp.last);
                        end
                    end
                end
            end
        end
        else
            in_xfer = 1'b0;
    end

    // A start transfer followed by a number of step transfers with junk data
    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input int steps);
        line_item_t it;
        it.func = alr_pkg::FUNC_START;
        it.sx = sx[15:0];
        it.sy = sy[15:0];
        it.ex = ex[15:0];
        it.ey = ey[15:0];
        stim_items.push_back(it);
        repeat (steps)
        begin
            it = {alr_pkg::FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom)};
            stim_items.push_back(it);
        end
    endtask

    // Wait until all items are sent and all pairs have arrived, then let the block settle
    task automatic drain();
        while (stim_items.size() > 0 || drv_busy || pending_pairs.size() > 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
    endtask

    // Mostly complete lines of random content; some abandoned, some long or wild
    task automatic queue_random_lines(input int count);
        int queued, r, sx, sy, dx, dy, ex, ey, span, steps;
        queued = 0;
        while (queued < count)
        begin
            r = $urandom_range(99);
            sx = $urandom_range(65535);
            sy = $urandom_range(65535);
            if (r < 3)
            begin
                ex = $urandom_range(65535);
                ey = $urandom_range(65535);
                steps = $urandom_range(1, 40);
            end
            else
            begin
                span = (r < 10) ? 1600 : 160;
                dx = $urandom_range(span);
                dy = $urandom_range(span);
                ex = $urandom_range(1) ? sx + dx : sx - dx;
                if (ex < 0 || ex > 65535)
                    ex = 2 * sx - ex;
                ey = $urandom_range(1) ? sy + dy : sy - dy;
                if (ey < 0 || ey > 65535)
                    ey = 2 * sy - ey;
                steps = (((dx > dy) ? dx : dy) >> CF) + 2;
                if (r < 20)
                    steps = $urandom_range(steps);
                else if (r < 28)
                    steps += $urandom_range(1, 2);
            end
            queue_line(sx, sy, ex, ey, steps);
            queued += 1 + steps;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: step with no line, coincident endpoints, corners, steep, abandon
        stim_items.push_back({alr_pkg::FUNC_STEP, 64'hFFFF_FFFF_FFFF_FFFF});
        queue_line(0, 0, 0, 0, 2);
        queue_line(65535, 65535, 65535, 65535, 2);
        queue_line(1, 0, 60, 20, 5);
        queue_line(65535, 0, 65500, 60, 5);
        queue_line(32, 32, 320, 48, 1);
        queue_line(8, 65520, 40, 65520, 3);
        drain();

        // Long receiver hold-off while a long line keeps the input busy
        hold_req++;
        queue_line(0, 0, 1280, 480, 85);
        drain();

        queue_random_lines(70);
        drain();
        send_idle_pct = 83;
        queue_random_lines(70);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 83;
        queue_random_lines(70);
        drain();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        queue_random_lines(70);
        drain();

        if (mismatches == 0 && pending_pairs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
